/* sv/floyd_steinberg_bilevel_dither_assert.svh */
`ifndef FLOYD_STEINBERG_BILEVEL_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_BILEVEL_DITHER_ASSERT_SVH

// Assertion macros: implication in the same cycle and in the next cycle.
`ifndef SYNTH
`define FSBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define FSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define FSBD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/fsbd_pkg.sv */
package fsbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned GREY_W     = 8;
  localparam int unsigned ERR_W      = 8;
  localparam int unsigned LW_W       = 13;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WGT_W      = 4;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

  localparam logic [WGT_W-1:0] WGT_UP_LEFT  = 4'd1;
  localparam logic [WGT_W-1:0] WGT_UP       = 4'd5;
  localparam logic [WGT_W-1:0] WGT_UP_RIGHT = 4'd3;
  localparam logic [WGT_W-1:0] WGT_LEFT     = 4'd7;
  localparam int unsigned      WGT_SHIFT    = 4;

  typedef enum logic [0:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic x_pos;
    logic y_pos;
    logic last_col;
    logic last_row;
  } pix_flags_t;

  function automatic logic [GREY_W-1:0] add_clamped(
    input logic [GREY_W-1:0]       acc,
    input logic signed [ERR_W-1:0] e,
    input logic [WGT_W-1:0]        wgt
  );
    logic signed [11:0] prod;
    logic signed [11:0] sum;
    logic [GREY_W-1:0]  res;
    prod = $signed({{4{e[ERR_W-1]}}, e}) * $signed({8'd0, wgt});
    sum  = $signed({4'd0, acc}) + (prod >>> WGT_SHIFT);
    if (sum < 0) begin
      res = '0;
    end else if (sum > $signed({4'd0, GREY_MAX})) begin
      res = GREY_MAX;
    end else begin
      res = sum[GREY_W-1:0];
    end
    return res;
  endfunction

endpackage

/* sv/floyd_steinberg_bilevel_dither.sv */
// Bilevel error-diffusion dither of an 8-bit grey pixel stream.
// in_*   : one grey pixel per request, raster order, in_tdata[7:0] = grey_in.
// out_*  : one dithered pixel per input; out_tdata[0] = bit_out, out_tlast = row_end,
//          out_tuser = frame_end.
// cfg_*  : register writes (index 0 line_width, index 1 frame_height), always ready;
//          write only while no pixel is in flight.
// Pipeline: a pixel accepted into the input register passes one correction stage
// and then the output register before it shows on out_*.
// Throughput: one pixel per clock unless out_* stalls; the line store is read at the
// column and the column to its right when the pixel is taken, written when corrected.
// Reset: counters, pending pixels and the neighbor errors clear; registers go to
// 640 x 480. The line store holds no reset; each entry is written one row before
// it is read.
// Stall: while out_tready is low the result holds, the stage behind it holds one
// more pixel, and in_tready drops until the result is taken.
module floyd_steinberg_bilevel_dither #(
  parameter int unsigned MAX_WIDTH = fsbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] grey_in
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] bit_out, [7:1] zero
  output logic                             out_tlast,  // row_end
  output logic                             out_tuser,  // [0] frame_end
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [fsbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsbd_pkg::*;

`include "floyd_steinberg_bilevel_dither_assert.svh"

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [LW_W-1:0]   line_width_r;
  logic [FH_W-1:0]   frame_height_r;

  logic              accept;
  logic              fire;

  logic [AW-1:0]     pos_x;
  pix_flags_t        pos_flags;
  logic              col_zero;

  logic              s1_valid_r;
  logic [GREY_W-1:0] s1_grey_r;
  pix_flags_t        s1_flags_r;
  logic [AW-1:0]     s1_x_r;

  logic [ERR_W-1:0]  rd_up;
  logic [ERR_W-1:0]  rd_up_right;
  logic [ERR_W-1:0]  left_err_r;
  logic [ERR_W-1:0]  above_err_r;

  logic              dit_bit;
  logic [ERR_W-1:0]  dit_err;

  logic              out_valid_r;
  logic              out_bit_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data[LW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign accept    = in_tvalid && in_tready;

  fsbd_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .line_width   (line_width_r),
    .frame_height (frame_height_r),
    .x            (pos_x),
    .flags        (pos_flags),
    .col_zero     (col_zero)
  );

  fsbd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk    (clk),
    .we     (fire),
    .waddr  (s1_x_r),
    .wdata  (dit_err),
    .re     (accept),
    .raddr0 (pos_x),
    .raddr1 (pos_x + AW'(1)),
    .rdata0 (rd_up),
    .rdata1 (rd_up_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_grey_r  <= in_tdata[GREY_W-1:0];
      s1_flags_r <= pos_flags;
      s1_x_r     <= pos_x;
    end
  end

  fsbd_diffuse u_diffuse (
    .grey         (s1_grey_r),
    .flags        (s1_flags_r),
    .err_up_left  (above_err_r),
    .err_up       (rd_up),
    .err_up_right (rd_up_right),
    .err_left     (left_err_r),
    .bit_out      (dit_bit),
    .err_out      (dit_err)
  );

  // hold the left and up-left errors; drop both at row end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_err_r  <= '0;
      above_err_r <= '0;
    end else if (fire) begin
      left_err_r  <= s1_flags_r.last_col ? '0 : dit_err;
      above_err_r <= s1_flags_r.last_col ? '0 : rd_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_bit_r       <= dit_bit;
      out_row_end_r   <= s1_flags_r.last_col;
      out_frame_end_r <= s1_flags_r.last_col && s1_flags_r.last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};
  assign out_tlast  = out_row_end_r;
  assign out_tuser  = out_frame_end_r;

  `FSBD_ASSERT_SAME(a_frame_end_on_row_end, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `FSBD_ASSERT_NEXT(a_col_advances, clk, rst_n, accept && !pos_flags.last_col, !col_zero)
  `FSBD_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_tvalid)
  `FSBD_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !s1_valid_r, in_tready)

endmodule

/* sv/fsbd_line_mem.sv */
module fsbd_line_mem #(
  parameter int unsigned DEPTH = fsbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(fsbd_pkg::MAX_WIDTH_DEF)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fsbd_pkg::ERR_W-1:0]    wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr0,
  input  logic [AW-1:0]                 raddr1,
  output logic [fsbd_pkg::ERR_W-1:0]    rdata0,
  output logic [fsbd_pkg::ERR_W-1:0]    rdata1
);
  import fsbd_pkg::*;

  logic [ERR_W-1:0] mem [DEPTH];
  logic [ERR_W-1:0] rdata0_r;
  logic [ERR_W-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a read of the address written at the same edge sees the new error
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= (we && waddr == raddr0) ? wdata : mem[raddr0];
      rdata1_r <= (we && waddr == raddr1) ? wdata : mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

/* sv/fsbd_pos.sv */
module fsbd_pos #(
  parameter int unsigned MAX_WIDTH = fsbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(fsbd_pkg::MAX_WIDTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [fsbd_pkg::LW_W-1:0]   line_width,
  input  logic [fsbd_pkg::FH_W-1:0]   frame_height,
  output logic [AW-1:0]               x,
  output fsbd_pkg::pix_flags_t        flags,
  output logic                        col_zero
);
  import fsbd_pkg::*;

  localparam int unsigned WW = (AW + 1 > LW_W) ? AW + 1 : LW_W;
  localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);

  logic [AW-1:0]   col_r;
  logic [AW-1:0]   col_nxt;
  logic [FH_W-1:0] row_r;
  logic [FH_W-1:0] row_nxt;

  logic [WW-1:0]   w_nz;
  logic [WW-1:0]   w_sat;
  logic [WW-1:0]   w_m1;
  logic [FH_W-1:0] h_m1;

  always_comb begin
    w_nz  = (line_width == '0) ? WW'(1) : WW'(line_width);
    w_sat = (w_nz > WMAX) ? WMAX : w_nz;
    w_m1  = w_sat - WW'(1);
    h_m1  = (frame_height == '0) ? '0 : frame_height - FH_W'(1);

    flags.last_col = (WW'(col_r) >= w_m1);
    flags.last_row = (row_r >= h_m1);
    x              = flags.last_col ? w_m1[AW-1:0] : col_r;
    flags.x_pos    = (x != '0);
    flags.y_pos    = (row_r != '0);

    if (flags.last_col) begin
      col_nxt = '0;
      row_nxt = flags.last_row ? '0 : row_r + FH_W'(1);
    end else begin
      col_nxt = x + AW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col_zero = (col_r == '0);

endmodule

/* sv/fsbd_diffuse.sv */
module fsbd_diffuse (
  input  logic [fsbd_pkg::GREY_W-1:0]       grey,
  input  fsbd_pkg::pix_flags_t              flags,
  input  logic signed [fsbd_pkg::ERR_W-1:0] err_up_left,
  input  logic signed [fsbd_pkg::ERR_W-1:0] err_up,
  input  logic signed [fsbd_pkg::ERR_W-1:0] err_up_right,
  input  logic signed [fsbd_pkg::ERR_W-1:0] err_left,
  output logic                              bit_out,
  output logic [fsbd_pkg::ERR_W-1:0]        err_out
);
  import fsbd_pkg::*;

  logic [GREY_W-1:0] v_ul;
  logic [GREY_W-1:0] v_up;
  logic [GREY_W-1:0] v_ur;
  logic [GREY_W-1:0] v;

  always_comb begin
    v_ul = (flags.y_pos && flags.x_pos) ? add_clamped(grey, err_up_left, WGT_UP_LEFT) : grey;
    v_up = flags.y_pos ? add_clamped(v_ul, err_up, WGT_UP) : v_ul;
    v_ur = (flags.y_pos && !flags.last_col) ? add_clamped(v_up, err_up_right, WGT_UP_RIGHT)
                                            : v_up;
    v    = flags.x_pos ? add_clamped(v_ur, err_left, WGT_LEFT) : v_ur;

    bit_out = v[GREY_W-1];
    err_out = v[GREY_W-1] ? ERR_W'(v - GREY_MAX) : v;
  end

endmodule

/* verif/fsbd_dither_checker.sv */
`timescale 1ns / 100ps

module fsbd_dither_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] grey_in
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [7:0]                      out_tdata,  // [0] bit_out, [7:1] zero
  input  logic                            out_tlast,  // row_end
  input  logic                            out_tuser,  // [0] frame_end
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [fsbd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              open_pixels
);
  import fsbd_pkg::*;

  localparam int STORE_DEPTH  = MAX_WIDTH_DEF;
  localparam int THRESHOLD    = 128;

  typedef struct packed {
    logic bit_out;
    logic row_end;
    logic frame_end;
  } dither_result_t;

  logic [LW_W-1:0]         line_width;
  logic [FH_W-1:0]         frame_height;
  logic [11:0]             col_pos;
  logic [15:0]             row_pos;
  logic signed [ERR_W-1:0] prev_row_err [STORE_DEPTH];
  logic signed [ERR_W-1:0] left_err;
  logic signed [ERR_W-1:0] up_left_err;
  dither_result_t          expected_pixels [$];
  dither_result_t          want;
  int                      errors = 0;

  function automatic int diffuse(int acc, logic signed [ERR_W-1:0] err, int weight);
    int sum;
    sum = acc + ((int'(err) * weight) >>> WGT_SHIFT);
    if (sum < 0) begin
      return 0;
    end
    if (sum > int'(GREY_MAX)) begin
      return int'(GREY_MAX);
    end
    return sum;
  endfunction

  function automatic dither_result_t dither_pixel(logic [GREY_W-1:0] grey);
    int                      w;
    int                      h;
    int                      x;
    int                      y;
    int                      v;
    int                      e;
    logic                    last_col;
    logic                    last_row;
    logic signed [ERR_W-1:0] up_err;
    dither_result_t          res;
    w = (line_width == 0) ? 1 : int'(line_width);
    if (w > STORE_DEPTH) begin
      w = STORE_DEPTH;
    end
    h = (frame_height == 0) ? 1 : int'(frame_height);
    x = int'(col_pos);
    y = int'(row_pos);
    last_col = (x >= w - 1);
    last_row = (y >= h - 1);
    if (x >= w) begin
      x = w - 1;
    end
    v = int'(grey);
    up_err = '0;
    if (y > 0) begin
      up_err = prev_row_err[x];
      if (x > 0) begin
        v = diffuse(v, up_left_err, int'(WGT_UP_LEFT));
      end
      v = diffuse(v, up_err, int'(WGT_UP));
      if (!last_col) begin
        v = diffuse(v, prev_row_err[x+1], int'(WGT_UP_RIGHT));
      end
    end
    if (x > 0) begin
      v = diffuse(v, left_err, int'(WGT_LEFT));
    end
    e = (v < THRESHOLD) ? v : v - int'(GREY_MAX);
    prev_row_err[x] = e[ERR_W-1:0];
    left_err = e[ERR_W-1:0];
    up_left_err = up_err;
    res.bit_out = (v >= THRESHOLD);
    res.row_end = last_col;
    res.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      left_err = '0;
      up_left_err = '0;
      row_pos = last_row ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos = 12'(x + 1);
    end
    return res;
  endfunction

  task automatic report(string what, int exp_val, int act_val);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_width = LINE_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      col_pos = '0;
      row_pos = '0;
      left_err = '0;
      up_left_err = '0;
      expected_pixels.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual tdata %0d tlast %0d tuser %0d",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata !== {7'd0, want.bit_out}) begin
            report("bit_out", int'({7'd0, want.bit_out}), int'(out_tdata));
          end
          if (out_tlast !== want.row_end) begin
            report("row_end", int'(want.row_end), int'(out_tlast));
          end
          if (out_tuser !== want.frame_end) begin
            report("frame_end", int'(want.frame_end), int'(out_tuser));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(dither_pixel(in_tdata));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_LINE_WIDTH: begin
            line_width = cfg_data[LW_W-1:0];
          end
          CFG_FRAME_HEIGHT: begin
            frame_height = cfg_data[FH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= errors;
    open_pixels <= expected_pixels.size();
  end

endmodule

/* verif/tb_floyd_steinberg_bilevel_dither.sv */
`timescale 1ns / 100ps

module tb_floyd_steinberg_bilevel_dither;
  import fsbd_pkg::*;

  localparam int RANDOM_PIXELS = 1200;
  localparam int SAT_PIXELS    = 64;
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 64;
  localparam int DRAIN_CYCLES  = 4;

  typedef enum int {
    GREY_UNIFORM,
    GREY_EXTREME,
    GREY_THRESHOLD,
    GREY_FLAT
  } grey_style_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int          fail_count;
  int          open_pixels;
  int          quiet_cycles = 0;
  int          rx_beats     = 0;
  int          eff_width    = 640;
  int          flat_level   = 0;
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;
  bit          frame_closed = 1'b1;
  grey_style_t grey_style   = GREY_UNIFORM;

  floyd_steinberg_bilevel_dither u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fsbd_dither_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .open_pixels (open_pixels)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold off now and then so the pipeline fills and in_tready drops
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle ? $urandom_range(0, 3) : 0;
      if (rx_beats % 500 == 250) begin
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      frame_closed = out_tuser;
      rx_beats++;
    end
  end

  function automatic int width_of(logic [CFG_DATA_W-1:0] data);
    int lw;
    lw = int'(data[LW_W-1:0]);
    if (lw == 0) begin
      return 1;
    end
    return (lw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : lw;
  endfunction

  function automatic logic [7:0] pick_grey();
    int v;
    case (grey_style)
      GREY_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 255;
          2: v = 127;
          default: v = 128;
        endcase
      end
      GREY_THRESHOLD: begin
        v = $urandom_range(112, 143);
      end
      GREY_FLAT: begin
        v = flat_level + $urandom_range(0, 8) - 4;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end
      default: begin
        v = $urandom_range(0, 255);
      end
    endcase
    return 8'(v);
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LINE_WIDTH) begin
      eff_width = width_of(data);
    end
  endtask

  task automatic send_grey(logic [7:0] grey);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= grey;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_pixels != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] corner_greys [4] = '{8'd0, 8'd255, 8'd127, 8'd128};
    logic [7:0] swing_greys [9] = '{8'd255, 8'd0, 8'd127, 8'd128, 8'd255,
                                    8'd0, 8'd128, 8'd127, 8'd255};
    int         sent_random;
    int         count;
    int         width;
    sent_random = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero width and height act as one: every pixel ends a frame
    write_reg(CFG_LINE_WIDTH, 16'd0);
    write_reg(CFG_FRAME_HEIGHT, 16'd0);
    foreach (corner_greys[i]) send_grey(corner_greys[i]);
    wait_idle();

    // full-swing errors, clamping at both ends
    write_reg(CFG_LINE_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    foreach (swing_greys[i]) send_grey(swing_greys[i]);
    wait_idle();

    // shrink both registers mid-frame: the width past the current column, the height to the current row
    write_reg(CFG_LINE_WIDTH, 16'd4);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    grey_style = GREY_EXTREME;
    repeat (6) send_grey(pick_grey());
    wait_idle();
    write_reg(CFG_LINE_WIDTH, 16'd1);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    send_grey(8'd200);
    wait_idle();

    while (sent_random < RANDOM_PIXELS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      grey_style = grey_style_t'($urandom_range(0, 3));
      flat_level = $urandom_range(0, 255);
      if (frame_closed) begin
        width = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
        write_reg(CFG_LINE_WIDTH, {3'($urandom), 13'(width)});
        write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
      end else if ($urandom_range(0, 1) == 0) begin
        // mid-frame: never widen, so no unwritten line entry is read
        write_reg(CFG_LINE_WIDTH, {3'($urandom), 13'($urandom_range(0, eff_width))});
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
        end
      end
      count = $urandom_range(1, 60);
      repeat (count) send_grey(pick_grey());
      sent_random += count;
      wait_idle();
    end

    // close the open frame before widening
    if (!frame_closed) begin
      write_reg(CFG_FRAME_HEIGHT, 16'd0);
      grey_style = GREY_UNIFORM;
      do begin
        send_grey(pick_grey());
        wait_idle();
      end while (!frame_closed);
    end

    // saturated width, start of the first row
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    grey_style = GREY_UNIFORM;
    write_reg(CFG_LINE_WIDTH, 16'hFFFF);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    repeat (SAT_PIXELS) send_grey(pick_grey());
    wait_idle();

    if (fail_count == 0 && open_pixels == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
